>>> design/kmt_pkg.sv
package kmt_pkg;

   localparam int KEY_W         = 64;
   localparam int AMOUNT_W      = 32;
   localparam int MAX_W         = 31;
   localparam int STAMP_W       = 64;
   localparam int ENTRIES_DEFAULT = 8;
   localparam int ENTRIES_MAX   = 64;
   // slot number fields are sized for the largest table supported
   localparam int SLOT_IDX_W    = $clog2(ENTRIES_MAX);

   typedef struct packed {
      logic        [KEY_W-1:0]    item_key;
      logic signed [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [AMOUNT_W-1:0] known_maximum;
      logic signed [AMOUNT_W-1:0] requested_amount;
   } rsp_type;

   // lookup state handed from cell to cell along the chain
   typedef struct packed {
      logic                  hit;
      logic                  empty;
      logic [SLOT_IDX_W-1:0] hit_slot;
      logic [SLOT_IDX_W-1:0] empty_slot;
      logic [SLOT_IDX_W-1:0] victim_slot;
      logic [MAX_W-1:0]      hit_max;
      logic [STAMP_W-1:0]    oldest;
   } sweep_type;

   // slot update broadcast to every cell
   typedef struct packed {
      logic                  en;
      logic                  miss;
      logic [SLOT_IDX_W-1:0] slot;
      logic [KEY_W-1:0]      key;
      logic [MAX_W-1:0]      value;
      logic [STAMP_W-1:0]    stamp;
   } write_type;

endpackage

>>> design/keyed_max_tracker_lru_table_unit.sv
// A tracked request is looked up along the cell chain, committed to its slot
//   and then presented from the response register; a request whose key is zero
//   or whose amount is not positive skips the lookup and the commit.
// Only one request is in flight: a new one is not taken until the last has
//   walked the chain and been loaded into the response register.
// Reset: synchronous, active high; empties all slots, clears counter and hold mode.
module keyed_max_tracker_lru_table_unit #(
   parameter int ENTRIES = kmt_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmt_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import kmt_pkg::*;

   localparam int CntW = $clog2(ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic signed [AMOUNT_W-1:0] amount_ff, amount_in;
   logic                   bypass_ff, bypass_in;
   logic [STAMP_W-1:0]     stamp_counter_ff, stamp_counter_in;
   logic                   hold_mode_ff, hold_mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_xfer;
   logic                   out_free;
   logic                   commit;
   logic [MAX_W-1:0]       amount_low;
   logic [MAX_W-1:0]       new_max;
   logic signed [AMOUNT_W-1:0] known_max;
   sweep_type              sweep_chain [ENTRIES+1];
   sweep_type              result;
   write_type              wr;

   // ---------------------------------------------------------------------
   // Handshakes. One request is in flight at a time; the response register
   // parts the two sides, so a new request is taken while a response waits.
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Cell chain. The head gets a fresh lookup token each cycle; each cell
   // folds its slot into it and hands it on. Since the key and the table stay
   // put during the search, the tail shows the full lookup once the token has
   // passed every cell's register.
   // ---------------------------------------------------------------------
   always_comb begin
      sweep_chain[0]             = '0;
      sweep_chain[0].oldest      = '1;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      kmt_cell #(
         .SLOT (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .lookup_key (key_ff),
         .prev_sweep (sweep_chain[g]),
         .next_sweep (sweep_chain[g+1]),
         .wr         (wr)
      );
   end

   assign result = sweep_chain[ENTRIES];

   // ---------------------------------------------------------------------
   // Commit. A hit updates its slot; a miss claims the highest empty slot or
   // else the least recently stamped one. A positive amount fits 31 bits.
   // ---------------------------------------------------------------------
   assign commit     = (state_ff == ST_DONE) && out_free && !bypass_ff;
   assign amount_low = amount_ff[MAX_W-1:0];

   always_comb begin
      if (!result.hit || (amount_low > result.hit_max)) begin
         new_max = amount_low;
      end else begin
         new_max = result.hit_max;
      end
   end

   assign known_max = AMOUNT_W'({1'b0, new_max});

   always_comb begin
      wr       = '0;
      wr.en    = commit;
      wr.miss  = !result.hit;
      wr.key   = key_ff;
      wr.value = amount_low;
      wr.stamp = stamp_counter_ff + STAMP_W'(1);
      if (result.hit) begin
         wr.slot = result.hit_slot;
      end else if (result.empty) begin
         wr.slot = result.empty_slot;
      end else begin
         wr.slot = result.victim_slot;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      key_in           = key_ff;
      amount_in        = amount_ff;
      bypass_in        = bypass_ff;
      stamp_counter_in = stamp_counter_ff;
      hold_mode_in     = hold_mode_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         hold_mode_in = csr_data;
      end

      // drop the response once it has been taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               key_in    = req_data.item_key;
               amount_in = req_data.amount;
               cnt_in    = '0;
               // no key or a non-positive amount skips the table entirely
               bypass_in = (req_data.item_key == '0) || req_data.amount[AMOUNT_W-1]
                           || (req_data.amount == '0);
               if (bypass_in) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // advance until the token has cleared the last cell
            if (cnt_ff == CntW'(ENTRIES - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (bypass_ff) begin
                  rsp_data_in.known_maximum    = amount_ff;
                  rsp_data_in.requested_amount = amount_ff;
               end else begin
                  rsp_data_in.known_maximum    = known_max;
                  rsp_data_in.requested_amount = hold_mode_ff ? known_max : amount_ff;
                  stamp_counter_in             = wr.stamp;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         bypass_ff        <= 1'b0;
         stamp_counter_ff <= '0;
         hold_mode_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         bypass_ff        <= bypass_in;
         stamp_counter_ff <= stamp_counter_in;
         hold_mode_ff     <= hold_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      amount_ff   <= amount_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while another is in flight");

   a_commit_when_done: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_DONE) && !bypass_ff && out_free)
      else $error("table written outside the commit step");

   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> stamp_counter_ff == $past(stamp_counter_ff) + STAMP_W'(1))
      else $error("stamp counter did not advance on commit");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> rsp_valid_ff)
      else $error("commit without a response");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (cnt_ff <= CntW'(ENTRIES - 1)))
      else $error("search count out of range");
`endif

endmodule

>>> design/kmt_cell.sv
module kmt_cell #(
   parameter int SLOT = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [kmt_pkg::KEY_W-1:0]   lookup_key,
   input  kmt_pkg::sweep_type          prev_sweep,
   output kmt_pkg::sweep_type          next_sweep,
   input  kmt_pkg::write_type          wr
);
   import kmt_pkg::*;

   logic [KEY_W-1:0]   key_ff,   key_in;
   logic [MAX_W-1:0]   max_ff,   max_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   sweep_type          sweep_ff, sweep_in;
   logic               selected;

   assign selected = wr.en && (wr.slot == SLOT_IDX_W'(SLOT));

   // fold this slot into the lookup state; a hit upstream freezes it
   always_comb begin
      sweep_in = prev_sweep;
      if (!prev_sweep.hit) begin
         if (key_ff == lookup_key) begin
            sweep_in.hit      = 1'b1;
            sweep_in.hit_slot = SLOT_IDX_W'(SLOT);
            sweep_in.hit_max  = max_ff;
         end else if (key_ff == '0) begin
            sweep_in.empty      = 1'b1;
            sweep_in.empty_slot = SLOT_IDX_W'(SLOT);
         end else if (stamp_ff < prev_sweep.oldest) begin
            sweep_in.victim_slot = SLOT_IDX_W'(SLOT);
            sweep_in.oldest      = stamp_ff;
         end
      end
   end

   always_comb begin
      key_in   = key_ff;
      max_in   = max_ff;
      stamp_in = stamp_ff;
      if (selected) begin
         if (wr.miss) begin
            key_in = wr.key;
            max_in = wr.value;
         end else if (wr.value > max_ff) begin
            max_in = wr.value;
         end
         stamp_in = wr.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         max_ff   <= '0;
         stamp_ff <= '0;
      end else begin
         key_ff   <= key_in;
         max_ff   <= max_in;
         stamp_ff <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff <= sweep_in;
   end

   assign next_sweep = sweep_ff;

endmodule
